### hw/rtl/tosb_pkg.sv
// Shared types, codes and microcode program of the time-ordered sample buffer.
`default_nettype none

package tosb_pkg;

  localparam int STAMP_W     = 64;
  localparam int PAYLOAD_W   = 64;
  localparam int WINDOW_W    = 63;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int UPC_W       = 5;
  localparam int OP_W        = 4;
  localparam int COND_W      = 4;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 63'd10000000000;

  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [UPC_W-1:0]       upc_t;
  typedef logic [OP_W-1:0]        op_t;
  typedef logic [COND_W-1:0]      cond_t;

  localparam status_t ST_STORED   = 2'd0;
  localparam status_t ST_REJECTED = 2'd1;
  localparam status_t ST_CLEARED  = 2'd2;

  localparam cfg_index_t CFG_STATIC_MODE      = 2'd0;
  localparam cfg_index_t CFG_RETENTION_WINDOW = 2'd1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_TAKE       = 4'd1;
  localparam op_t OP_SCAN_INIT  = 4'd2;
  localparam op_t OP_SCAN       = 4'd3;
  localparam op_t OP_PLACE      = 4'd4;
  localparam op_t OP_APPEND     = 4'd5;
  localparam op_t OP_FIRST      = 4'd6;
  localparam op_t OP_CLEAR      = 4'd7;
  localparam op_t OP_REJECT     = 4'd8;
  localparam op_t OP_PRUNE_INIT = 4'd9;
  localparam op_t OP_PRUNE      = 4'd10;
  localparam op_t OP_EMIT       = 4'd11;

  localparam cond_t C_NEVER    = 4'd0;
  localparam cond_t C_ALWAYS   = 4'd1;
  localparam cond_t C_NO_IN    = 4'd2;
  localparam cond_t C_CLEAR    = 4'd3;
  localparam cond_t C_STATIC   = 4'd4;
  localparam cond_t C_EMPTY    = 4'd5;
  localparam cond_t C_TOO_OLD  = 4'd6;
  localparam cond_t C_IN_ORDER = 4'd7;
  localparam cond_t C_SCAN_GO  = 4'd8;
  localparam cond_t C_PRUNE_GO = 4'd9;
  localparam cond_t C_OUT_FULL = 4'd10;

  localparam upc_t PC_IDLE       = 5'd0;
  localparam upc_t PC_DISPATCH   = 5'd1;
  localparam upc_t PC_CHK_STATIC = 5'd2;
  localparam upc_t PC_CHK_EMPTY  = 5'd3;
  localparam upc_t PC_CHK_OLD    = 5'd4;
  localparam upc_t PC_CHK_ORDER  = 5'd5;
  localparam upc_t PC_SCAN_INIT  = 5'd6;
  localparam upc_t PC_SCAN       = 5'd7;
  localparam upc_t PC_PLACE      = 5'd8;
  localparam upc_t PC_CLEAR      = 5'd9;
  localparam upc_t PC_FIRST      = 5'd10;
  localparam upc_t PC_REJECT     = 5'd11;
  localparam upc_t PC_APPEND     = 5'd12;
  localparam upc_t PC_PRUNE_INIT = 5'd13;
  localparam upc_t PC_PRUNE      = 5'd14;
  localparam upc_t PC_EMIT       = 5'd15;
  localparam upc_t PC_DONE       = 5'd16;
  localparam upc_t PC_LAST       = PC_DONE;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_clear;
    logic static_on;
    logic empty;
    logic too_old;
    logic in_order;
    logic scan_go;
    logic prune_go;
    logic out_full;
  } flags_t;

  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:       w = '{OP_TAKE,       C_NO_IN,    PC_IDLE};
      PC_DISPATCH:   w = '{OP_NOP,        C_CLEAR,    PC_CLEAR};
      PC_CHK_STATIC: w = '{OP_NOP,        C_STATIC,   PC_FIRST};
      PC_CHK_EMPTY:  w = '{OP_NOP,        C_EMPTY,    PC_FIRST};
      PC_CHK_OLD:    w = '{OP_NOP,        C_TOO_OLD,  PC_REJECT};
      PC_CHK_ORDER:  w = '{OP_NOP,        C_IN_ORDER, PC_APPEND};
      PC_SCAN_INIT:  w = '{OP_SCAN_INIT,  C_NEVER,    PC_IDLE};
      PC_SCAN:       w = '{OP_SCAN,       C_SCAN_GO,  PC_SCAN};
      PC_PLACE:      w = '{OP_PLACE,      C_ALWAYS,   PC_PRUNE_INIT};
      PC_CLEAR:      w = '{OP_CLEAR,      C_ALWAYS,   PC_EMIT};
      PC_FIRST:      w = '{OP_FIRST,      C_ALWAYS,   PC_EMIT};
      PC_REJECT:     w = '{OP_REJECT,     C_ALWAYS,   PC_EMIT};
      PC_APPEND:     w = '{OP_APPEND,     C_NEVER,    PC_IDLE};
      PC_PRUNE_INIT: w = '{OP_PRUNE_INIT, C_NEVER,    PC_IDLE};
      PC_PRUNE:      w = '{OP_PRUNE,      C_PRUNE_GO, PC_PRUNE};
      PC_EMIT:       w = '{OP_EMIT,       C_OUT_FULL, PC_EMIT};
      PC_DONE:       w = '{OP_NOP,        C_ALWAYS,   PC_IDLE};
      default:       w = '{OP_NOP,        C_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tosb_if.sv
// Handshake channel interfaces for items, results and configuration writes.
`default_nettype none

interface tosb_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic signed [63:0]   stamp;
  logic [63:0]          payload;
  modport source (output valid, output kind, output stamp, output payload, input ready);
  modport sink   (input valid, input kind, input stamp, input payload, output ready);
endinterface

interface tosb_out_if #(parameter int COUNT_BITS = 6);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [COUNT_BITS-1:0] entry_count;
  logic signed [63:0]    newest_stamp;
  modport source (output valid, output status, output entry_count, output newest_stamp,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input newest_stamp,
                  output ready);
endinterface

interface tosb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/tosb_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module tosb_seq import tosb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  upc_t   upc;
  upc_t   upc_next;
  uword_t word;
  logic   hit;

  assign word = ucode_rom(upc);

  always_comb begin
    unique case (word.cond)
      C_NEVER:    hit = 1'b0;
      C_ALWAYS:   hit = 1'b1;
      C_NO_IN:    hit = !flags.in_valid;
      C_CLEAR:    hit = flags.is_clear;
      C_STATIC:   hit = flags.static_on;
      C_EMPTY:    hit = flags.empty;
      C_TOO_OLD:  hit = flags.too_old;
      C_IN_ORDER: hit = flags.in_order;
      C_SCAN_GO:  hit = flags.scan_go;
      C_PRUNE_GO: hit = flags.prune_go;
      C_OUT_FULL: hit = flags.out_full;
      default:    hit = 1'b0;
    endcase
  end

  assign upc_next = hit ? word.target : upc + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= PC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctrl.op   = word.op;
  assign ctrl.take = (word.op == OP_TAKE);

  a_upc_range: assert property (@(posedge clk) disable iff (rst) upc <= PC_LAST)
    else $error("step counter outside program");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (upc == PC_IDLE) && !flags.in_valid |=> (upc == PC_IDLE))
    else $error("left idle without an item");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (upc == PC_EMIT) && !flags.out_full |=> (upc == PC_DONE))
    else $error("emit step did not complete");

endmodule

`default_nettype wire

### hw/rtl/time_ordered_sample_buffer.sv
// Top level: entry memory, walk datapath and result register under microcode control.
// A stored insert, unless the buffer is empty or in static mode, walks the memory's single
// read port one entry per cycle: once to sort an out-of-order stamp into place, once to
// prune; both walks cover at most CAPACITY-1 entries.
// One item at a time; the next item is taken only after its result is registered.
// Synchronous active-high reset empties the buffer and restores the register defaults.
`default_nettype none

module time_ordered_sample_buffer import tosb_pkg::*; #(
  parameter int CAPACITY     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  tosb_in_if.sink      item,
  tosb_out_if.source   result,
  tosb_cfg_if.sink     cfg
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  logic [STAMP_W-1:0]      stamp_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_mem   [CAPACITY];

  ctrl_t  ctrl;
  flags_t flags;

  logic                    static_mode;
  logic [WINDOW_W-1:0]     window;
  logic [AW-1:0]           head;
  logic [CW-1:0]           occ;
  logic                    res_valid;

  logic                    kind_r;
  logic [STAMP_W-1:0]      stamp_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [STAMP_W-1:0]      newest;
  status_t                 status_r;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           lim;

  logic [STAMP_W-1:0]      rd_stamp;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [AW-1:0]           rd_ptr;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           rd_ptr_inc;
  logic [AW-1:0]           rd_ptr_dec;
  logic [AW-1:0]           head_inc;
  logic [AW-1:0]           tail;
  logic [CW-1:0]           occ_m1;
  logic [CW-1:0]           head_w;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [STAMP_W-1:0]      wr_stamp;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  logic [STAMP_W-1:0]      age_stamp;
  logic [STAMP_W:0]        age;
  logic                    too_old;
  logic                    item_acc;

  status_t                 res_status;
  logic [CW-1:0]           res_count;
  logic [STAMP_W-1:0]      res_newest;

  tosb_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign item.ready = ctrl.take && !rst;
  assign item_acc   = item.valid && item.ready;
  assign cfg.ready  = !rst;

  assign rd_ptr_inc = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
  assign rd_ptr_dec = (rd_ptr == '0) ? LAST_SLOT : rd_ptr - 1'b1;
  assign head_inc   = (head == LAST_SLOT) ? '0 : head + 1'b1;

  assign occ_m1 = occ - 1'b1;
  assign head_w = CW'(head);
  assign tail   = (head_w >= occ_m1) ? AW'(head_w - occ_m1)
                                     : AW'(head_w + CW'(CAPACITY) - occ_m1);

  // exact test: stamp < newest - window
  assign age_stamp = (ctrl.op == OP_PRUNE) ? rd_stamp : stamp_r;
  assign age       = {newest[STAMP_W-1], newest} - {age_stamp[STAMP_W-1], age_stamp};
  assign too_old   = !age[STAMP_W] && (age[STAMP_W-1:0] > {1'b0, window});

  assign flags.in_valid  = item.valid;
  assign flags.is_clear  = (kind_r == KIND_CLEAR);
  assign flags.static_on = static_mode;
  assign flags.empty     = (occ == '0);
  assign flags.too_old   = too_old;
  assign flags.in_order  = !($signed(stamp_r) < $signed(newest));
  assign flags.scan_go   = (idx != lim) && ($signed(stamp_r) < $signed(rd_stamp));
  assign flags.prune_go  = (occ > CW'(1)) && too_old;
  assign flags.out_full  = res_valid && !result.ready;

  always_comb begin
    rd_addr  = rd_ptr;
    wr_en    = 1'b0;
    wr_addr  = rd_ptr_inc;
    wr_stamp = rd_stamp;
    wr_pay   = rd_pay;
    unique case (ctrl.op)
      OP_SCAN_INIT: begin
        rd_addr = head;
      end
      OP_SCAN: begin
        if (flags.scan_go) begin
          wr_en   = 1'b1;
          rd_addr = rd_ptr_dec;
        end
      end
      OP_PLACE: begin
        wr_en    = 1'b1;
        wr_stamp = stamp_r;
        wr_pay   = payload_r;
      end
      OP_APPEND: begin
        wr_en    = 1'b1;
        wr_addr  = head_inc;
        wr_stamp = stamp_r;
        wr_pay   = payload_r;
      end
      OP_FIRST: begin
        wr_en    = 1'b1;
        wr_addr  = '0;
        wr_stamp = stamp_r;
        wr_pay   = payload_r;
      end
      OP_PRUNE_INIT: begin
        rd_addr = tail;
      end
      OP_PRUNE: begin
        if (flags.prune_go) begin
          rd_addr = rd_ptr_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
      pay_mem[wr_addr]   <= wr_pay;
    end
    rd_stamp <= stamp_mem[rd_addr];
    rd_pay   <= pay_mem[rd_addr];
    rd_ptr   <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      static_mode <= 1'b0;
      window      <= WINDOW_RESET;
      head        <= '0;
      occ         <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_STATIC_MODE) begin
          static_mode <= cfg.data[0];
        end else if (cfg.index == CFG_RETENTION_WINDOW) begin
          window <= cfg.data[WINDOW_W-1:0];
        end
      end
      if ((ctrl.op == OP_EMIT) && !flags.out_full) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_SCAN_INIT: begin
          if (occ != CW'(CAPACITY)) begin
            occ <= occ + 1'b1;
          end
        end
        OP_PLACE: begin
          head <= head_inc;
        end
        OP_APPEND: begin
          head <= head_inc;
          if (occ != CW'(CAPACITY)) begin
            occ <= occ + 1'b1;
          end
        end
        OP_FIRST: begin
          head <= '0;
          occ  <= CW'(1);
        end
        OP_CLEAR: begin
          head <= '0;
          occ  <= '0;
        end
        OP_PRUNE: begin
          if (flags.prune_go) begin
            occ <= occ_m1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      kind_r    <= item.kind;
      stamp_r   <= item.stamp;
      payload_r <= item.payload[PAYLOAD_BITS-1:0];
    end
    unique case (ctrl.op)
      OP_SCAN_INIT: begin
        idx <= '0;
        lim <= (occ == CW'(CAPACITY)) ? LAST_SLOT : AW'(occ);
      end
      OP_SCAN: begin
        if (flags.scan_go) begin
          idx <= idx + 1'b1;
        end
      end
      OP_PLACE: begin
        status_r <= ST_STORED;
      end
      OP_APPEND, OP_FIRST: begin
        newest   <= stamp_r;
        status_r <= ST_STORED;
      end
      OP_CLEAR: begin
        status_r <= ST_CLEARED;
      end
      OP_REJECT: begin
        status_r <= ST_REJECTED;
      end
      OP_EMIT: begin
        if (!flags.out_full) begin
          res_status <= status_r;
          res_count  <= occ;
          res_newest <= (occ == '0) ? '0 : newest;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid        = res_valid;
  assign result.status       = res_status;
  assign result.entry_count  = res_count;
  assign result.newest_stamp = res_newest;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst) head <= LAST_SLOT)
    else $error("head slot outside ring");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_SCAN) |-> (idx <= lim))
    else $error("sort walk ran past the window");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_CLEARED) |-> (res_count == '0))
    else $error("clear result reports entries");

endmodule

`default_nettype wire

### tb/sv/time_ordered_sample_buffer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench: drives inserts and clears, predicts each word from a ring model.
module time_ordered_sample_buffer_test import tosb_pkg::*;;

  localparam int DEPTH = 32;
  localparam int COUNT_W = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int MAX_REPORTS = 10;
  localparam cfg_index_t CFG_SPARE_A = 2'd2;
  localparam cfg_index_t CFG_SPARE_B = 2'd3;
  localparam logic signed [63:0] STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] STAMP_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] SCALE_CAP = 64'h0000_1000_0000_0000;
  localparam logic [63:0] WIN_DEFAULT = {1'b0, WINDOW_RESET};

  typedef struct packed {
    logic               kind;
    logic signed [63:0] stamp;
    logic [63:0]        payload;
  } sample_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic signed [63:0] newest;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tosb_in_if item_ch();
  tosb_out_if #(.COUNT_BITS(COUNT_W)) result_ch();
  tosb_cfg_if cfg_ch();

  time_ordered_sample_buffer #(
    .CAPACITY(DEPTH),
    .PAYLOAD_BITS(64)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [63:0] ring_stamp [DEPTH];
  logic [63:0]        ring_payload [DEPTH];
  int unsigned        ring_head = 0;
  int unsigned        ring_fill = 0;
  logic               model_static = 1'b0;
  logic [WINDOW_W-1:0] model_window = WINDOW_RESET;

  sample_t  pending_q[$];
  outcome_t expected_q[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_request = 1'b0;
  logic hold_results = 1'b0;
  int   idle_cycles = 0;
  int   accepted_items = 0;
  int   seen_results = 0;
  int   mismatches = 0;
  int   stored_n = 0;
  int   rejected_n = 0;
  int   cleared_n = 0;
  int   full_hits = 0;

  function automatic int unsigned slot_at(int unsigned age);
    return (ring_head + DEPTH - age) % DEPTH;
  endfunction

  // exact test of s < anchor - window, widened so nothing wraps
  function automatic logic is_expired(logic signed [63:0] s, logic signed [63:0] anchor);
    logic signed [65:0] lhs;
    logic signed [65:0] limit;
    lhs = $signed({{2{s[63]}}, s});
    limit = $signed({{2{anchor[63]}}, anchor}) - $signed({3'b000, model_window});
    return lhs < limit;
  endfunction

  function automatic void settle_order();
    logic signed [63:0] key_s;
    logic [63:0]        key_p;
    int unsigned        j;
    for (int unsigned i = 1; i < ring_fill; i++) begin
      key_s = ring_stamp[slot_at(i)];
      key_p = ring_payload[slot_at(i)];
      j = i;
      while (j > 0 && ring_stamp[slot_at(j - 1)] < key_s) begin
        ring_stamp[slot_at(j)] = ring_stamp[slot_at(j - 1)];
        ring_payload[slot_at(j)] = ring_payload[slot_at(j - 1)];
        j--;
      end
      ring_stamp[slot_at(j)] = key_s;
      ring_payload[slot_at(j)] = key_p;
    end
  endfunction

  function automatic outcome_t predict_outcome(sample_t s);
    outcome_t o;
    logic     ordered;
    o.status = ST_STORED;
    if (s.kind == KIND_CLEAR) begin
      ring_fill = 0;
      ring_head = 0;
      o.status = ST_CLEARED;
    end else if (model_static) begin
      ring_stamp[0] = s.stamp;
      ring_payload[0] = s.payload;
      ring_head = 0;
      ring_fill = 1;
    end else if (ring_fill != 0 && is_expired(s.stamp, ring_stamp[ring_head])) begin
      o.status = ST_REJECTED;
    end else if (ring_fill == 0) begin
      ring_head = 0;
      ring_fill = 1;
      ring_stamp[0] = s.stamp;
      ring_payload[0] = s.payload;
    end else begin
      ordered = s.stamp >= ring_stamp[ring_head];
      ring_head = (ring_head + 1) % DEPTH;
      if (ring_fill < DEPTH) ring_fill++;
      ring_stamp[ring_head] = s.stamp;
      ring_payload[ring_head] = s.payload;
      if (!ordered) settle_order();
    end
    if (o.status == ST_STORED) begin
      while (ring_fill > 1 &&
             is_expired(ring_stamp[slot_at(ring_fill - 1)], ring_stamp[ring_head]))
        ring_fill--;
    end
    o.count = COUNT_W'(ring_fill);
    o.newest = (ring_fill != 0) ? ring_stamp[ring_head] : '0;
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_below(logic [63:0] span);
    if (span == '1) return rand64();
    return rand64() % (span + 64'd1);
  endfunction

  task automatic push_item(logic kind, logic [63:0] stamp, logic [63:0] payload);
    sample_t s;
    s.kind = kind;
    s.stamp = stamp;
    s.payload = payload;
    pending_q.push_back(s);
  endtask

  task automatic flag_mismatch(string why, outcome_t want, outcome_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"tb: mismatch (%s) want status %0d count %0d newest %0d,",
                " got status %0d count %0d newest %0d"},
               why, want.status, want.count, want.newest, got.status, got.count, got.newest);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_STATIC_MODE:      model_static = value[0];
      CFG_RETENTION_WINDOW: model_window = value[WINDOW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || expected_q.size() != 0 || item_ch.valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // runs of rising stamps with jitter, each opened by a clear with even odds, plus some noise
  task automatic queue_runs(int total);
    logic signed [63:0] cursor;
    logic [63:0]        scale;
    logic [63:0]        step_span;
    logic [63:0]        win;
    int                 left;
    int                 n;
    int                 pick;
    cursor = '0;
    left = total;
    while (left > 0) begin
      win = {1'b0, model_window};
      scale = (model_window == '0) ? 64'd6 : win;
      if (scale > SCALE_CAP && $urandom_range(3) != 0) scale = SCALE_CAP;
      step_span = scale >> $urandom_range(1, 7);
      n = $urandom_range(8, 45);
      if (n > left) n = left;
      left -= n;
      if ($urandom_range(1) == 1) begin
        push_item(KIND_CLEAR, rand64(), rand64());
        case ($urandom_range(3))
          0: cursor = rand64();
          1: cursor = STAMP_MAX - rand_below(scale);
          2: cursor = STAMP_MIN + rand_below(64'd16);
          default: cursor = rand_below(64'd1000);
        endcase
      end
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          cursor += rand_below(step_span);
          push_item(KIND_INSERT, cursor, rand64());
        end else if (pick < 88) begin
          push_item(KIND_INSERT, cursor - rand_below(scale), rand64());
        end else if (pick < 92) begin
          push_item(KIND_INSERT, cursor - win - rand_below(64'd1), rand64());
        end else if (pick < 97) begin
          push_item(KIND_INSERT, rand64(), rand64());
        end else begin
          push_item(KIND_CLEAR, rand64(), rand64());
        end
      end
    end
  endtask

  always @(posedge clk) begin : item_driver
    sample_t offered;
    sample_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      offered = '{item_ch.kind, item_ch.stamp, item_ch.payload};
      if (item_ch.valid && item_ch.ready) begin
        expected_q.push_back(predict_outcome(offered));
        accepted_items++;
      end
      if (!(item_ch.valid && !item_ch.ready)) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.kind <= nxt.kind;
          item_ch.stamp <= nxt.stamp;
          item_ch.payload <= nxt.payload;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    outcome_t got;
    outcome_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.status, result_ch.entry_count, result_ch.newest_stamp};
        if (expected_q.size() == 0) begin
          flag_mismatch("no word expected", '0, got);
        end else begin
          want = expected_q.pop_front();
          seen_results++;
          case (want.status)
            ST_STORED:   stored_n++;
            ST_REJECTED: rejected_n++;
            default:     cleared_n++;
          endcase
          if (want.count == DEPTH) full_hits++;
          if (got.status !== want.status || got.count !== want.count ||
              got.newest !== want.newest)
            flag_mismatch("field differs", want, got);
        end
      end
    end
  end

  initial begin : receiver_hold
    wait (hold_request);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_INSERT;
    item_ch.stamp = '0;
    item_ch.payload = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_STATIC_MODE;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_idling(26, 70);
    push_item(KIND_CLEAR, STAMP_MAX, '1);
    push_item(KIND_INSERT, 64'd0, '0);
    push_item(KIND_INSERT, 64'd0, '1);
    push_item(KIND_INSERT, -64'sd5, 64'h5555_5555_5555_5555);
    push_item(KIND_INSERT, -64'sd5, 64'hAAAA_AAAA_AAAA_AAAA);
    push_item(KIND_INSERT, -WIN_DEFAULT, rand64());
    push_item(KIND_INSERT, -WIN_DEFAULT - 64'd1, rand64());
    push_item(KIND_INSERT, WIN_DEFAULT, rand64());
    push_item(KIND_INSERT, STAMP_MAX, rand64());
    push_item(KIND_INSERT, STAMP_MIN, rand64());
    push_item(KIND_INSERT, STAMP_MAX - WIN_DEFAULT, rand64());
    push_item(KIND_INSERT, STAMP_MAX - WIN_DEFAULT - 64'd1, rand64());
    push_item(KIND_CLEAR, '0, '0);
    push_item(KIND_INSERT, STAMP_MIN, rand64());
    push_item(KIND_INSERT, STAMP_MIN + 64'sd1, rand64());
    push_item(KIND_INSERT, STAMP_MAX, rand64());
    push_item(KIND_CLEAR, rand64(), rand64());
    push_item(KIND_CLEAR, rand64(), rand64());
    settle();

    write_reg(CFG_STATIC_MODE, 64'd0);
    write_reg(CFG_RETENTION_WINDOW, 64'd1000);
    queue_runs(125);
    settle();

    set_idling(70, 26);
    write_reg(CFG_RETENTION_WINDOW, {1'b1, 63'(rand64())});
    write_reg(CFG_STATIC_MODE, '1);
    push_item(KIND_INSERT, STAMP_MAX, rand64());
    push_item(KIND_INSERT, STAMP_MIN, rand64());
    push_item(KIND_CLEAR, rand64(), rand64());
    push_item(KIND_INSERT, rand64(), rand64());
    queue_runs(110);
    settle();

    write_reg(CFG_STATIC_MODE, 64'd0);
    write_reg(CFG_RETENTION_WINDOW, 64'd0);
    queue_runs(125);
    settle();

    set_idling(0, 0);
    write_reg(CFG_RETENTION_WINDOW, '1);
    push_item(KIND_INSERT, STAMP_MAX, rand64());
    push_item(KIND_INSERT, STAMP_MIN, rand64());
    queue_runs(125);
    hold_request <= 1'b1;
    settle();

    write_reg(CFG_RETENTION_WINDOW, rand_below(64'hFF_FFFF_FFFF));
    write_reg(CFG_SPARE_A, rand64());
    write_reg(CFG_SPARE_B, rand64());
    queue_runs(125);
    settle();

    $display("tb: %0d items in, %0d words checked: %0d stored, %0d rejected, %0d cleared",
             accepted_items, seen_results, stored_n, rejected_n, cleared_n);
    $display("tb: full ring seen %0d times over six register settings, %0d mismatches",
             full_hits, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
